// ===== hdl/hbd_pkg.sv =====
// Shared types, constants and helpers for the HTTP body deframer.
// No dependencies; compile first.
package hbd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_LENGTH  = 3'd1,
        ST_SIZE    = 3'd2,
        ST_EXT     = 3'd3,
        ST_DATA    = 3'd4,
        ST_AFTER   = 3'd5,
        ST_TRAILER = 3'd6,
        ST_FINAL   = 3'd7
    } body_state_t;

    typedef enum logic [2:0] {
        K_FRAME     = 3'd0,
        K_PAYLOAD   = 3'd1,
        K_DONE      = 3'd2,
        K_DONE_KEEP = 3'd3,
        K_ERROR     = 3'd4
    } out_kind_t;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;
    localparam logic MODE_CHUNKED = 1'b1;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_SEMI = 8'h3B;

    localparam int HEX_BITS = 4;

    typedef struct packed {
        logic        req_type;
        logic        body_mode;
        logic [31:0] body_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        out_kind_t  out_kind;
        logic [7:0] payload_byte;
    } result_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    endfunction

    function automatic logic [HEX_BITS-1:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[8'h30:8'h39]})
            v = c - 8'h30;
        else if (c inside {[8'h61:8'h66]})
            v = c - 8'h57;
        else
            v = c - 8'h37;
        return v[HEX_BITS-1:0];
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c inside {CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
    endfunction

endpackage

// ===== hdl/hbd_if.sv =====
// Valid/ready channel interfaces for the deframer's byte input and result output.
// No package dependencies; compile after hbd_pkg.
interface hbd_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        body_mode;
    logic [31:0] body_length;
    logic [7:0]  data_byte;

    modport source (output valid, output req_type, output body_mode,
                    output body_length, output data_byte, input ready);
    modport sink   (input valid, input req_type, input body_mode,
                    input body_length, input data_byte, output ready);
endinterface

interface hbd_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] out_kind;
    logic [7:0] payload_byte;

    modport source (output valid, output out_kind, output payload_byte, input ready);
    modport sink   (input valid, input out_kind, input payload_byte, output ready);
endinterface

// ===== hdl/hbd_core.sv =====
// Next-state and result logic of the deframer for one item.
// Depends on hbd_pkg.
module hbd_core
    import hbd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  item_t                  item,
    input  body_state_t            state,
    input  logic [COUNT_BITS-1:0]  bytes_left,
    input  logic                   at_line_start,
    output body_state_t            state_next,
    output logic [COUNT_BITS-1:0]  bytes_left_next,
    output logic                   at_line_start_next,
    output result_t                result
);

    localparam int LEN_BITS = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    logic [LEN_BITS-1:0]   len_ext;
    logic                  len_ovf;
    logic [COUNT_BITS-1:0] bl_dec;
    logic [7:0]            c;

    assign len_ext = LEN_BITS'(item.body_length);
    assign len_ovf = (len_ext >> COUNT_BITS) != '0;
    assign bl_dec  = bytes_left - COUNT_BITS'(1);
    assign c       = item.data_byte;

    always_comb
    begin
        state_next         = state;
        bytes_left_next    = bytes_left;
        at_line_start_next = at_line_start;
        result.out_kind    = K_FRAME;
        result.payload_byte = '0;

        if (item.req_type == REQ_START)
        begin
            at_line_start_next = 1'b1;
            if (item.body_mode == MODE_CHUNKED)
            begin
                state_next      = ST_SIZE;
                bytes_left_next = '0;
            end
            else if (len_ovf)
            begin
                state_next      = ST_IDLE;
                bytes_left_next = '0;
                result.out_kind = K_ERROR;
            end
            else if (item.body_length == '0)
            begin
                state_next      = ST_IDLE;
                bytes_left_next = '0;
                result.out_kind = K_DONE;
            end
            else
            begin
                state_next      = ST_LENGTH;
                bytes_left_next = len_ext[COUNT_BITS-1:0];
            end
        end
        else
        begin
            case (state)
                ST_LENGTH, ST_DATA:
                begin
                    result.out_kind     = K_PAYLOAD;
                    result.payload_byte = c;
                    bytes_left_next     = bl_dec;
                    if (bl_dec == '0)
                        state_next = (state == ST_LENGTH) ? ST_IDLE : ST_AFTER;
                end
                ST_SIZE, ST_EXT:
                begin
                    if (c == CH_LF)
                    begin
                        if (bytes_left == '0)
                        begin
                            state_next         = ST_TRAILER;
                            at_line_start_next = 1'b1;
                        end
                        else
                            state_next = ST_DATA;
                    end
                    else if (state == ST_SIZE)
                    begin
                        if (is_hex(c))
                        begin
                            // digit would push set bits out of the counter
                            if (bytes_left[COUNT_BITS-1 -: HEX_BITS] != '0)
                            begin
                                state_next      = ST_IDLE;
                                bytes_left_next = '0;
                                result.out_kind = K_ERROR;
                            end
                            else
                                bytes_left_next = {bytes_left[COUNT_BITS-HEX_BITS-1:0],
                                                   hex_value(c)};
                        end
                        else if (is_blank(c))
                            result.out_kind = K_FRAME;
                        else if (c == CH_SEMI)
                            state_next = ST_EXT;
                        else
                        begin
                            state_next      = ST_IDLE;
                            bytes_left_next = '0;
                            result.out_kind = K_ERROR;
                        end
                    end
                end
                ST_AFTER:
                begin
                    if (c == CH_LF)
                    begin
                        state_next      = ST_SIZE;
                        bytes_left_next = '0;
                    end
                    else if (c != CH_CR)
                    begin
                        state_next      = ST_IDLE;
                        bytes_left_next = '0;
                        result.out_kind = K_ERROR;
                    end
                end
                ST_TRAILER:
                begin
                    if (c == CH_LF)
                    begin
                        if (at_line_start)
                            state_next = ST_FINAL;
                        at_line_start_next = 1'b1;
                    end
                    else if (c != CH_CR)
                        at_line_start_next = 1'b0;
                end
                ST_FINAL:
                begin
                    if (c != CH_CR && c != CH_SP)
                    begin
                        state_next      = ST_IDLE;
                        result.out_kind = (c == CH_LF) ? K_DONE : K_DONE_KEEP;
                    end
                end
                default:
                    result.out_kind = K_DONE_KEEP;
            endcase
        end
    end

endmodule

// ===== hdl/http_body_deframer_unit.sv =====
// HTTP request body deframer: length and chunked framing, one result per item.
// Usage:
//   req carries items: req_type 0 starts a body (body_mode, body_length),
//   req_type 1 delivers data_byte. rsp returns one result per item:
//   out_kind (framing, payload, done, done-keep-byte, error) and payload_byte.
//   An item is taken when valid and ready are both high.
// Timing:
//   Accepted items land in an input register; the state update and result
//   are computed from it and written to the result register once that
//   register is empty or its result is being taken.
//   Throughput is one item per cycle while rsp.ready stays high, set by
//   the registered update of the body state and byte counter.
// Stalls:
//   If rsp is not taken, the result register holds, the input register
//   keeps one more item, and req.ready falls until rsp.ready returns.
// Reset:
//   rst_n clears both registers' valid flags; body state goes idle,
//   counter zero, line-start flag set. Depends on hbd_pkg, hbd_if, hbd_core.
module http_body_deframer_unit
    import hbd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    hbd_in_if.sink       req,
    hbd_out_if.source    rsp
);

    logic                  in_valid_reg;
    item_t                 in_item_reg;
    logic                  out_valid_reg;
    result_t               out_result_reg;

    body_state_t           body_state_reg, body_state_next;
    logic [COUNT_BITS-1:0] bytes_left_reg, bytes_left_next;
    logic                  at_line_start_reg, at_line_start_next;
    result_t               core_result;

    logic                  advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    hbd_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .item               (in_item_reg),
        .state              (body_state_reg),
        .bytes_left         (bytes_left_reg),
        .at_line_start      (at_line_start_reg),
        .state_next         (body_state_next),
        .bytes_left_next    (bytes_left_next),
        .at_line_start_next (at_line_start_next),
        .result             (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            body_state_reg    <= ST_IDLE;
            bytes_left_reg    <= '0;
            at_line_start_reg <= 1'b1;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                body_state_reg    <= body_state_next;
                bytes_left_reg    <= bytes_left_next;
                at_line_start_reg <= at_line_start_next;
            end
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg.req_type    <= req.req_type;
            in_item_reg.body_mode   <= req.body_mode;
            in_item_reg.body_length <= req.body_length;
            in_item_reg.data_byte   <= req.data_byte;
        end
        if (advance)
            out_result_reg <= core_result;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.out_kind     = out_result_reg.out_kind;
    assign rsp.payload_byte = out_result_reg.payload_byte;

    // counter is clear in the idle, trailer and final states
    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (body_state_reg == ST_IDLE || body_state_reg == ST_TRAILER ||
         body_state_reg == ST_FINAL) |-> (bytes_left_reg == '0))
        else $error("byte counter nonzero outside a counted state");

    a_data_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (body_state_reg == ST_LENGTH || body_state_reg == ST_DATA)
        |-> (bytes_left_reg != '0))
        else $error("data state with empty counter");

    a_payload_source: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_result.out_kind == K_PAYLOAD)
        |-> (body_state_reg == ST_LENGTH || body_state_reg == ST_DATA))
        else $error("payload result outside a data state");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule
